/* rtl/core/button_click_classifier_macros.svh */
// Assertion macros used by the button click classifier checker.
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bcc_pkg.sv */
// Types, register codes and reset values for the button click classifier.
`default_nettype none
package bcc_pkg;

  localparam int unsigned TicksW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TicksW-1:0] DebounceRst  = 16'd5;
  localparam logic [TicksW-1:0] ClickGapRst  = 16'd40;
  localparam logic [TicksW-1:0] LongPressRst = 16'd100;
  localparam logic [TicksW-1:0] FreeCountRst = 16'd50;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_CLICK_GAP  = 3'd1,
    REG_LONG_PRESS = 3'd2,
    REG_FREE_COUNT = 3'd3,
    REG_INVERT     = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_DEBOUNCE   = 4'd1,
    PH_PRESSED    = 4'd2,
    PH_CLICK_UP   = 4'd3,
    PH_CLICK_IDLE = 4'd4,
    PH_SINGLE     = 4'd5,
    PH_DBL_DEB    = 4'd6,
    PH_DOUBLE     = 4'd7,
    PH_TRI_IDLE   = 4'd8,
    PH_TRI_DEB    = 4'd9,
    PH_TRIPLE     = 4'd10,
    PH_LONG       = 4'd11,
    PH_OTHER_UP   = 4'd12
  } phase_e;

  typedef struct packed {
    logic [TicksW-1:0] debounce_ticks;
    logic [TicksW-1:0] click_gap_ticks;
    logic [TicksW-1:0] long_press_ticks;
    logic [TicksW-1:0] free_count;
    logic              invert_input;
  } cfg_t;

  typedef struct packed {
    logic              pin_level;
    logic [TicksW-1:0] now_ticks;
  } in_req_t;

  typedef struct packed {
    logic       single_click_event;
    logic       double_click_event;
    logic       triple_click_event;
    logic       long_click_event;
    logic       release_event;
    logic       button_free;
    logic [3:0] click_phase;
  } out_res_t;

  typedef struct packed {
    phase_e            phase;
    logic [TicksW-1:0] last_change;
    logic [TicksW-1:0] countdown;
    out_res_t          res;
  } upd_t;

endpackage
`default_nettype wire

/* rtl/core/bcc_fsm.sv */
// Next-state, timing and event logic of the click classifier for one request.
`default_nettype none
module bcc_fsm (
  input  bcc_pkg::cfg_t                  cfg_i,
  input  bcc_pkg::phase_e                phase_i,
  input  logic [bcc_pkg::TicksW-1:0]     last_change_i,
  input  logic [bcc_pkg::TicksW-1:0]     countdown_i,
  input  bcc_pkg::in_req_t               req_i,
  output bcc_pkg::upd_t                  upd_o
);
  import bcc_pkg::*;

  logic              pressed;
  logic [TicksW-1:0] diff;
  phase_e            nxt;
  logic              ev_single, ev_double, ev_triple, ev_long, ev_release;
  logic [TicksW-1:0] countdown_d;
  logic [TicksW-1:0] last_change_d;

  assign pressed = req_i.pin_level ^ cfg_i.invert_input;
  assign diff    = req_i.now_ticks - last_change_i;

  always_comb begin
    nxt           = phase_i;
    ev_single     = 1'b0;
    ev_double     = 1'b0;
    ev_triple     = 1'b0;
    ev_long       = 1'b0;
    ev_release    = 1'b0;
    countdown_d   = countdown_i;
    last_change_d = last_change_i;
    if (!pressed && phase_i == PH_IDLE) begin
      if (countdown_i != '0) begin
        countdown_d = countdown_i - 1'b1;
      end
    end else begin
      unique case (phase_i)
        PH_IDLE: nxt = PH_DEBOUNCE;
        PH_DEBOUNCE: begin
          if (!pressed) nxt = PH_IDLE;
          else if (diff > cfg_i.debounce_ticks) nxt = PH_PRESSED;
        end
        PH_PRESSED: begin
          if (!pressed) begin
            nxt = PH_CLICK_UP;
          end else if (diff > cfg_i.long_press_ticks) begin
            nxt     = PH_LONG;
            ev_long = 1'b1;
          end
        end
        PH_CLICK_UP: nxt = PH_CLICK_IDLE;
        PH_CLICK_IDLE: begin
          if (pressed) begin
            nxt = PH_DBL_DEB;
          end else if (diff >= cfg_i.click_gap_ticks) begin
            nxt       = PH_SINGLE;
            ev_single = 1'b1;
          end
        end
        PH_SINGLE: nxt = PH_IDLE;
        PH_DBL_DEB: begin
          if (!pressed) nxt = PH_CLICK_UP;
          else if (diff >= cfg_i.debounce_ticks) nxt = PH_DOUBLE;
        end
        PH_DOUBLE: begin
          if (!pressed) nxt = PH_TRI_IDLE;
        end
        PH_TRI_IDLE: begin
          if (pressed) begin
            nxt = PH_TRI_DEB;
          end else if (diff >= cfg_i.click_gap_ticks) begin
            nxt       = PH_IDLE;
            ev_double = 1'b1;
          end
        end
        PH_TRI_DEB: begin
          if (!pressed) begin
            nxt       = PH_IDLE;
            ev_double = 1'b1;
          end else if (diff > cfg_i.debounce_ticks) begin
            nxt       = PH_TRIPLE;
            ev_triple = 1'b1;
          end
        end
        PH_TRIPLE, PH_LONG: begin
          if (!pressed) begin
            nxt        = PH_OTHER_UP;
            ev_release = 1'b1;
          end
        end
        PH_OTHER_UP: nxt = PH_IDLE;
        default: nxt = phase_i;
      endcase
      if (nxt != phase_i) begin
        last_change_d = req_i.now_ticks;
        if (nxt == PH_IDLE) begin
          countdown_d = cfg_i.free_count;
        end
      end
    end
  end

  always_comb begin
    upd_o                        = '0;
    upd_o.phase                  = nxt;
    upd_o.last_change            = last_change_d;
    upd_o.countdown              = countdown_d;
    upd_o.res.single_click_event = ev_single;
    upd_o.res.double_click_event = ev_double;
    upd_o.res.triple_click_event = ev_triple;
    upd_o.res.long_click_event   = ev_long;
    upd_o.res.release_event      = ev_release;
    upd_o.res.button_free        = (nxt == PH_IDLE) && (countdown_d == '0);
    upd_o.res.click_phase        = nxt;
  end

endmodule
`default_nettype wire

/* rtl/core/button_click_classifier.sv */
// Top level of the button click classifier: registers, result queue and config port.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid_i/in_stall_o | in_req_i (pin level, ticks)
//   out     | output    | out_valid_o/out_stall_i | out_res_o (events, phase)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_wdata_i
//
// One request per cycle while in_stall_o is low; results enter the output queue.
// The classifier state updates in the accepting cycle, so back-to-back requests chain.
// A two-entry output queue (result register plus skid) absorbs a stalled result;
// in_stall_o rises only once the skid entry holds a result.
// Active-low async reset restores state and config and invalidates both queue entries.
`default_nettype none
module button_click_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bcc_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bcc_pkg::out_res_t               out_res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bcc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bcc_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import bcc_pkg::*;

  cfg_t              cfg_q;
  phase_e            phase_q;
  logic [TicksW-1:0] last_change_q;
  logic [TicksW-1:0] countdown_q;
  upd_t              upd;
  logic              in_fire;
  logic              out_fire;
  logic              out_valid_q, skid_valid_q;
  out_res_t          out_res_q, skid_res_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DebounceRst;
      cfg_q.click_gap_ticks  <= ClickGapRst;
      cfg_q.long_press_ticks <= LongPressRst;
      cfg_q.free_count       <= FreeCountRst;
      cfg_q.invert_input     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_wdata_i;
        REG_CLICK_GAP:  cfg_q.click_gap_ticks  <= cfg_wdata_i;
        REG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_wdata_i;
        REG_FREE_COUNT: cfg_q.free_count       <= cfg_wdata_i;
        REG_INVERT:     cfg_q.invert_input     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  bcc_fsm u_fsm (
    .cfg_i         (cfg_q),
    .phase_i       (phase_q),
    .last_change_i (last_change_q),
    .countdown_i   (countdown_q),
    .req_i         (in_req_i),
    .upd_o         (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      last_change_q <= '0;
      countdown_q   <= FreeCountRst;
    end else if (in_fire) begin
      phase_q       <= upd.phase;
      last_change_q <= upd.last_change;
      countdown_q   <= upd.countdown;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      out_res_q <= skid_valid_q ? skid_res_q : upd.res;
    end else if (in_fire) begin
      skid_res_q <= upd.res;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bcc_checker.sv */
// Port-level checks on the button click classifier and their binding.
`default_nettype none
`include "button_click_classifier_macros.svh"
module bcc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input bcc_pkg::in_req_t                in_req_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input bcc_pkg::out_res_t               out_res_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [bcc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input logic [bcc_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import bcc_pkg::*;

  logic [4:0] events;
  logic       unused_ok;

  assign events    = {out_res_o.single_click_event, out_res_o.double_click_event,
                      out_res_o.triple_click_event, out_res_o.long_click_event,
                      out_res_o.release_event};
  assign unused_ok = ^{in_valid_i, in_stall_o, in_req_i, cfg_valid_i, cfg_ready_o,
                       cfg_index_i, cfg_wdata_i};

  `BCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_res_o), "stalled result changed or dropped")
  `BCC_ASSERT_NOW(a_one_event, clk_i, rst_ni, out_valid_o,
    $countones(events) <= 1, "more than one click event in a result")
  `BCC_ASSERT_NOW(a_free_idle, clk_i, rst_ni, out_valid_o && out_res_o.button_free,
    out_res_o.click_phase == PH_IDLE, "button free outside idle phase")
  `BCC_ASSERT_NOW(a_release_phase, clk_i, rst_ni, out_valid_o && out_res_o.release_event,
    out_res_o.click_phase == PH_OTHER_UP, "release event without other-up phase")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);
`default_nettype wire
